// ===== design/magstripe_track_f2f_encoder_top_macros.svh =====
// Assertion macros shared by the encoder's checker.
`ifndef MAGSTRIPE_TRACK_F2F_ENCODER_TOP_MACROS_SVH
`define MAGSTRIPE_TRACK_F2F_ENCODER_TOP_MACROS_SVH

// Property checked on every rising edge, ignored while reset is high.
`define MSF2F_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define MSF2F_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/msf2f_pkg.sv =====
// Types, codes and the microcode table of the magstripe F2F encoder.
package msf2f_pkg;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] track_sel;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic bit_value;
    logic pole_first;
    logic pole_second;
    logic last;
  } out_item_t;

  // Command codes.
  localparam logic [1:0] MODE_BEGIN_CARD  = 2'd0;
  localparam logic [1:0] MODE_BEGIN_TRACK = 2'd1;
  localparam logic [1:0] MODE_DATA        = 2'd2;
  localparam logic [1:0] MODE_END_TRACK   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_LEAD_ZEROS_TRACK1 = 2'd0;
  localparam logic [1:0] REG_LEAD_ZEROS_TRACK2 = 2'd1;
  localparam logic [1:0] REG_LEAD_ZEROS_TRACK3 = 2'd2;
  localparam logic [1:0] REG_TAIL_ZEROS        = 2'd3;

  localparam logic [1:0] TRACK_ONE   = 2'd0;
  localparam logic [1:0] TRACK_TWO   = 2'd1;
  localparam logic [1:0] TRACK_THREE = 2'd2;

  localparam logic [5:0] ZERO_MAX      = 6'd48;
  localparam logic [7:0] OFFSET_TRACK1 = 8'd32;
  localparam logic [7:0] OFFSET_OTHER  = 8'd48;
  localparam logic [5:0] BITS_TRACK1   = 6'd6;
  localparam logic [5:0] BITS_OTHER    = 6'd4;

  // Sequencer steps.
  localparam logic [1:0] STEP_IDLE   = 2'd0;
  localparam logic [1:0] STEP_ZERO   = 2'd1;
  localparam logic [1:0] STEP_DATA   = 2'd2;
  localparam logic [1:0] STEP_PARITY = 2'd3;

  // Cell bit sources.
  localparam logic [1:0] SRC_ZERO   = 2'd0;
  localparam logic [1:0] SRC_SHIFT  = 2'd1;
  localparam logic [1:0] SRC_PARITY = 2'd2;

  // Jump conditions.
  localparam logic [1:0] COND_NEVER     = 2'd0;
  localparam logic [1:0] COND_DISPATCH  = 2'd1;
  localparam logic [1:0] COND_CNT_ONE   = 2'd2;
  localparam logic [1:0] COND_CHAR_DONE = 2'd3;

  typedef struct packed {
    logic       emit;
    logic [1:0] src;
    logic       dec_cnt;
    logic       shift;
    logic       load_tail;
    logic [1:0] cond;
    logic [1:0] jump_to;
    logic [1:0] next;
    logic       last_on_jump;
  } ctl_t;

  // One control word per step.
  function automatic ctl_t ctl_rom(input logic [1:0] step);
    ctl_t c;
    c = '0;
    case (step)
      STEP_IDLE: begin
        c.cond = COND_DISPATCH;
        c.next = STEP_IDLE;
      end
      STEP_ZERO: begin
        c.emit         = 1'b1;
        c.src          = SRC_ZERO;
        c.dec_cnt      = 1'b1;
        c.cond         = COND_CNT_ONE;
        c.jump_to      = STEP_IDLE;
        c.next         = STEP_ZERO;
        c.last_on_jump = 1'b1;
      end
      STEP_DATA: begin
        c.emit    = 1'b1;
        c.src     = SRC_SHIFT;
        c.dec_cnt = 1'b1;
        c.shift   = 1'b1;
        c.cond    = COND_CNT_ONE;
        c.jump_to = STEP_PARITY;
        c.next    = STEP_DATA;
      end
      STEP_PARITY: begin
        c.emit         = 1'b1;
        c.src          = SRC_PARITY;
        c.load_tail    = 1'b1;
        c.cond         = COND_CHAR_DONE;
        c.jump_to      = STEP_IDLE;
        c.next         = STEP_ZERO;
        c.last_on_jump = 1'b1;
      end
      default: begin
        c.cond = COND_NEVER;
        c.next = STEP_IDLE;
      end
    endcase
    return c;
  endfunction

  function automatic logic [5:0] sat_count(input logic [5:0] v);
    return (v > ZERO_MAX) ? ZERO_MAX : v;
  endfunction

endpackage

// ===== design/msf2f_stream_if.sv =====
// Valid/ready stream channel used for the encoder's input and output.
interface msf2f_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/magstripe_track_f2f_encoder_top.sv =====
// Top level of the magstripe F2F track encoder: microcoded bit-cell sequencer.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        mode, track_sel, char_in
//   out_ch   out  valid/ready        bit_value, pole_first, pole_second, last
//   cfg      in   cfg_we (no ready)  cfg_index, cfg_wdata
//
// A request is taken only while the sequencer sits in its idle step, and is
// decoded into the step register. Then one bit cell per cycle, unless the output
// stalls, goes through the single output register that every emitting step
// writes: none for begin-card, n leading zeros for begin-track, b data bits and
// parity for a data character (b = 6 on track one, else 4), and b LRC bits,
// parity and t trailing zeros for end-track; n and t are the saturated zero counts.
// Reset is synchronous: it returns the sequencer to idle, empties the output
// register, clears polarity, LRC and track, and loads the register defaults.
// A stalled output freezes the sequencer with the pending cell held.
module magstripe_track_f2f_encoder_top
  import msf2f_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [5:0] cfg_wdata,
  msf2f_stream_if.sink   in_ch,
  msf2f_stream_if.source out_ch
);

  // Configuration registers.
  logic [5:0] lead_zeros_track1;
  logic [5:0] lead_zeros_track2;
  logic [5:0] lead_zeros_track3;
  logic [5:0] tail_zeros;

  // Architectural state.
  logic       coil_pole;
  logic [5:0] lrc_accum;
  logic [1:0] current_track;

  // Sequencer and datapath registers.
  logic [1:0] step;
  logic [1:0] step_next;
  logic [5:0] cnt;
  logic [5:0] shreg;
  logic       parity;
  logic       is_data;

  logic       out_valid;
  out_item_t  out_data;

  ctl_t       ctl;
  logic       in_fire;
  logic       out_free;
  logic       adv;
  logic       cond_true;
  logic       cell_bit;
  logic       pole_first;
  logic       pole_second;
  logic [1:0] sel_sat;
  logic [5:0] lead_sat;
  logic [5:0] tail_sat;
  logic [1:0] disp_step;
  logic [7:0] char_off;
  logic [5:0] char_bits;
  logic [5:0] track_bits;

  assign ctl      = ctl_rom(step);
  assign in_ch.ready = (step == STEP_IDLE);
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid || out_ch.ready;
  assign adv      = (step == STEP_IDLE) ? in_fire : out_free;

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_data;

  // Command decode helpers.
  assign sel_sat  = (in_ch.data.track_sel == 2'd3) ? TRACK_THREE : in_ch.data.track_sel;
  assign tail_sat = sat_count(tail_zeros);
  assign track_bits = (current_track == TRACK_ONE) ? BITS_TRACK1 : BITS_OTHER;
  assign char_off = in_ch.data.char_in -
                    ((current_track == TRACK_ONE) ? OFFSET_TRACK1 : OFFSET_OTHER);
  assign char_bits = (current_track == TRACK_ONE) ? char_off[5:0] : {2'b00, char_off[3:0]};

  always_comb begin
    case (sel_sat)
      TRACK_ONE: lead_sat = sat_count(lead_zeros_track1);
      TRACK_TWO: lead_sat = sat_count(lead_zeros_track2);
      default:   lead_sat = sat_count(lead_zeros_track3);
    endcase
  end

  always_comb begin
    case (in_ch.data.mode)
      MODE_BEGIN_CARD:  disp_step = STEP_IDLE;
      MODE_BEGIN_TRACK: disp_step = (lead_sat == 6'd0) ? STEP_IDLE : STEP_ZERO;
      default:          disp_step = STEP_DATA;
    endcase
  end

  // Jump condition selected by the control word.
  always_comb begin
    case (ctl.cond)
      COND_CNT_ONE:   cond_true = (cnt == 6'd1);
      COND_CHAR_DONE: cond_true = is_data || (tail_sat == 6'd0);
      default:        cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (ctl.cond == COND_DISPATCH) begin
      step_next = disp_step;
    end else if (cond_true) begin
      step_next = ctl.jump_to;
    end else begin
      step_next = ctl.next;
    end
  end

  always_comb begin
    case (ctl.src)
      SRC_SHIFT:  cell_bit = shreg[0];
      SRC_PARITY: cell_bit = parity;
      default:    cell_bit = 1'b0;
    endcase
  end

  // Polarity flips at the start of every cell and again mid-cell on a one.
  assign pole_first  = ~coil_pole;
  assign pole_second = pole_first ^ cell_bit;

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_zeros_track1 <= 6'd10;
      lead_zeros_track2 <= 6'd20;
      lead_zeros_track3 <= 6'd10;
      tail_zeros        <= 6'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LEAD_ZEROS_TRACK1: lead_zeros_track1 <= cfg_wdata;
        REG_LEAD_ZEROS_TRACK2: lead_zeros_track2 <= cfg_wdata;
        REG_LEAD_ZEROS_TRACK3: lead_zeros_track3 <= cfg_wdata;
        REG_TAIL_ZEROS:        tail_zeros        <= cfg_wdata;
        default:               tail_zeros        <= tail_zeros;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STEP_IDLE;
      coil_pole     <= 1'b0;
      lrc_accum     <= 6'd0;
      current_track <= TRACK_ONE;
    end else if (adv) begin
      step <= step_next;
      if (step == STEP_IDLE) begin
        case (in_ch.data.mode)
          MODE_BEGIN_CARD: begin
            coil_pole <= 1'b0;
          end
          MODE_BEGIN_TRACK: begin
            current_track <= sel_sat;
            lrc_accum     <= 6'd0;
          end
          MODE_DATA: begin
            lrc_accum <= lrc_accum ^ char_bits;
          end
          default: begin
            lrc_accum <= lrc_accum;
          end
        endcase
      end else if (ctl.emit) begin
        coil_pole <= pole_second;
      end
    end
  end

  // Counter, shift register and parity carry no reset.
  always_ff @(posedge clk) begin
    if (adv) begin
      if (step == STEP_IDLE) begin
        parity  <= 1'b1;
        is_data <= (in_ch.data.mode == MODE_DATA);
        if (in_ch.data.mode == MODE_BEGIN_TRACK) begin
          cnt <= lead_sat;
        end else begin
          cnt <= track_bits;
        end
        shreg <= (in_ch.data.mode == MODE_DATA) ? char_off[5:0] : lrc_accum;
      end else begin
        if (ctl.dec_cnt) begin
          cnt <= cnt - 6'd1;
        end
        if (ctl.load_tail && !cond_true) begin
          cnt <= tail_sat;
        end
        if (ctl.shift) begin
          shreg  <= {1'b0, shreg[5:1]};
          parity <= parity ^ shreg[0];
        end
      end
    end
  end

  // Output register between the sequencer and the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step != STEP_IDLE && ctl.emit && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step != STEP_IDLE && ctl.emit && out_free) begin
      out_data.bit_value   <= cell_bit;
      out_data.pole_first  <= pole_first;
      out_data.pole_second <= pole_second;
      out_data.last        <= cond_true && ctl.last_on_jump;
    end
  end

endmodule

// ===== design/msf2f_checker.sv =====
// Port-level checks for the magstripe F2F encoder, bound to its top level.
`include "magstripe_track_f2f_encoder_top_macros.svh"

module msf2f_checker
  import msf2f_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       bit_value,
  input logic       pole_first,
  input logic       pole_second
);

  // A stalled cell stays offered.
  `MSF2F_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "stalled cell dropped")

  // The coil changes mid-cell exactly when the bit is a one.
  `MSF2F_ASSERT(a_mid_flip, out_valid |-> (pole_second == (pole_first ^ bit_value)),
    "mid-cell polarity does not match bit")

  // A begin-card request causes no cell, so the next request is taken at once.
  `MSF2F_ASSERT(a_card_quick, in_valid && in_ready && (in_mode == MODE_BEGIN_CARD) |=> in_ready,
    "begin card left the sequencer busy")

  // Reset empties the output register.
  `MSF2F_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "output valid after reset")

endmodule

bind magstripe_track_f2f_encoder_top msf2f_checker u_msf2f_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_mode     (in_ch.data.mode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .bit_value   (out_ch.data.bit_value),
  .pole_first  (out_ch.data.pole_first),
  .pole_second (out_ch.data.pole_second)
);
